### rtl/khrf_pkg.sv
// Shared types and constants for the hotkey report filter.
// Used by khrf_lane, khrf_merge and kvm_hotkey_report_filter; no dependencies.
package khrf_pkg;

  localparam int KEY_W       = 8;   // key usage code width
  localparam int LED_W       = 5;   // stored LED bits
  localparam int TGT_W       = 2;   // target code width
  localparam int STATUS_W    = LED_W + TGT_W;
  localparam int SLOT_FIELDS = 6;   // slot fields carried on the stream
  localparam int CFG_IDX_W   = 3;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_HOTKEY  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_B = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_A = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_B = 3'd4;

  // Target codes
  localparam logic [TGT_W-1:0] TGT_FIRST  = 2'd1;
  localparam logic [TGT_W-1:0] TGT_SECOND = 2'd2;

  // Reset values of the key registers
  localparam logic [KEY_W-1:0] RST_HOTKEY   = 8'd101;
  localparam logic [KEY_W-1:0] RST_FIRST_A  = 8'd80;
  localparam logic [KEY_W-1:0] RST_FIRST_B  = 8'd82;
  localparam logic [KEY_W-1:0] RST_SECOND_A = 8'd79;
  localparam logic [KEY_W-1:0] RST_SECOND_B = 8'd81;

  // Key codes compared in every lane
  typedef struct packed {
    logic [KEY_W-1:0] hot;
    logic [KEY_W-1:0] first_a;
    logic [KEY_W-1:0] first_b;
    logic [KEY_W-1:0] second_a;
    logic [KEY_W-1:0] second_b;
  } key_cfg_t;

  // Per-slot compare results
  typedef struct packed {
    logic hot;
    logic first_a;
    logic first_b;
    logic second_a;
    logic second_b;
  } lane_match_t;

  // Target update from the merge stage
  typedef struct packed {
    logic             update;
    logic [TGT_W-1:0] code;
  } tgt_sel_t;

endpackage

### rtl/khrf_lane.sv
// One slot lane: compares a key slot against all configured codes.
// Depends on khrf_pkg.
module khrf_lane (
  input  logic [khrf_pkg::KEY_W-1:0] slot,
  input  khrf_pkg::key_cfg_t         keys,
  output khrf_pkg::lane_match_t      match
);
  import khrf_pkg::*;

  // Five independent equality compares
  assign match.hot      = (slot == keys.hot);
  assign match.first_a  = (slot == keys.first_a);
  assign match.first_b  = (slot == keys.first_b);
  assign match.second_a = (slot == keys.second_a);
  assign match.second_b = (slot == keys.second_b);

endmodule

### rtl/khrf_merge.sv
// Merge stage: picks the slots to drop from the lane results, compacts the
// report and decides the target update. Depends on khrf_pkg.
module khrf_merge #(
  parameter int KEY_SLOTS = 6
) (
  input  logic [KEY_SLOTS-1:0][khrf_pkg::KEY_W-1:0] slots,
  input  khrf_pkg::lane_match_t [KEY_SLOTS-1:0]      match,
  input  khrf_pkg::lane_match_t                      fill_match,
  output logic [KEY_SLOTS-1:0][khrf_pkg::KEY_W-1:0] slots_out,
  output khrf_pkg::tgt_sel_t                         sel
);
  import khrf_pkg::*;

  // Lowest set bit as a one-hot
  function automatic logic [KEY_SLOTS-1:0] lowest(input logic [KEY_SLOTS-1:0] v);
    return v & (~v + KEY_SLOTS'(1));
  endfunction

  logic [KEY_SLOTS-1:0] hot_vec, fa_vec, fb_vec, sa_vec, sb_vec;
  logic [KEY_SLOTS-1:0] hot_oh, avail, fa_oh, fb_oh, sa_oh, sb_oh;
  logic [KEY_SLOTS-1:0] drop;

  // Gather per-code match vectors across lanes
  always_comb begin
    for (int i = 0; i < KEY_SLOTS; i++) begin
      hot_vec[i] = match[i].hot;
      fa_vec[i]  = match[i].first_a;
      fb_vec[i]  = match[i].first_b;
      sa_vec[i]  = match[i].second_a;
      sb_vec[i]  = match[i].second_b;
    end
  end

  // Arrow search skips the slot already taken by the hotkey
  assign hot_oh = lowest(hot_vec);
  assign avail  = ~hot_oh;
  assign fa_oh  = lowest(fa_vec & avail);
  assign fb_oh  = lowest(fb_vec & avail);
  assign sa_oh  = lowest(sa_vec & avail);
  assign sb_oh  = lowest(sb_vec & avail);

  // Priority: first target a, b, then second target a, b.
  // Once the hotkey is gone the last slot holds a zero fill, which an arrow
  // code of zero also finds; dropping that fill leaves the slots unchanged.
  always_comb begin
    drop       = '0;
    sel.update = 1'b0;
    sel.code   = TGT_FIRST;
    if (|hot_oh) begin
      sel.update = 1'b1;
      if (|fa_oh || fill_match.first_a) begin
        drop = hot_oh | fa_oh;
      end else if (|fb_oh || fill_match.first_b) begin
        drop = hot_oh | fb_oh;
      end else if (|sa_oh || fill_match.second_a) begin
        drop     = hot_oh | sa_oh;
        sel.code = TGT_SECOND;
      end else if (|sb_oh || fill_match.second_b) begin
        drop     = hot_oh | sb_oh;
        sel.code = TGT_SECOND;
      end else begin
        drop       = hot_oh;
        sel.update = 1'b0;
      end
    end
  end

  // Compaction: a kept slot moves down by the number of dropped slots below it
  always_comb begin
    int below;
    for (int j = 0; j < KEY_SLOTS; j++) begin
      slots_out[j] = '0;
    end
    for (int i = 0; i < KEY_SLOTS; i++) begin
      below = 0;
      for (int k = 0; k < i; k++) begin
        below = below + int'(drop[k]);
      end
      for (int j = 0; j < KEY_SLOTS; j++) begin
        if (!drop[i] && (i - below == j)) begin
          slots_out[j] = slots[i];
        end
      end
    end
  end

endmodule

### rtl/kvm_hotkey_report_filter.sv
// Top level of the hotkey report filter: stream ports, key registers,
// LED/target state and the output register. Depends on khrf_pkg, khrf_lane, khrf_merge.
//
//  port group | dir | tdata fields (low bit up)                         | tuser
//  s_*        | in  | link_byte, modifier_in, slot_in0..slot_in5 (64b)  | mode
//  m_*        | out | modifier_out, status_byte, slot_out0..5,          | -
//             |     | led_report, zero pad (72b)                        |
//  cfg_*      | in  | cfg_index selects a key register, cfg_data value  | -
//
// One item per cycle while s_tready is high. A report runs through KEY_SLOTS
// compare lanes and the merge stage in the cycle it is accepted; its result is
// registered in the output register. LED items update state and give no transfer.
// s_tready is low only while the output register holds a result that m_tready
// does not take. Synchronous reset restores the key codes, LEDs 0, target 1.
module kvm_hotkey_report_filter #(
  parameter int KEY_SLOTS = 6
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [63:0]                   s_tdata,  // link_byte, modifier_in, slot_in0..5
  input  logic                          s_tuser,  // mode
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [71:0]                   m_tdata,  // modifier_out, status_byte,
                                                  // slot_out0..5, led_report, pad
  input  logic                          cfg_we,
  input  logic [khrf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [khrf_pkg::KEY_W-1:0]    cfg_data
);
  import khrf_pkg::*;

  localparam int SLOT_LSB = 16;
  localparam int OUT_SLOT_LSB = KEY_W + STATUS_W;
  localparam int LED_LSB = OUT_SLOT_LSB + SLOT_FIELDS * KEY_W;
  localparam int OUT_USED = LED_LSB + LED_W;

  key_cfg_t               keys;
  logic [LED_W-1:0]       led_bits;
  logic [TGT_W-1:0]       target_code;
  logic [TGT_W-1:0]       target_next;
  logic                   accept;
  logic                   is_report;

  logic [KEY_SLOTS-1:0][KEY_W-1:0] lane_slot;
  logic [KEY_SLOTS-1:0][KEY_W-1:0] merged;
  lane_match_t [KEY_SLOTS-1:0]     match;
  lane_match_t                     fill_match;
  tgt_sel_t                        sel;
  logic [SLOT_FIELDS-1:0][KEY_W-1:0] out_slot;

  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign is_report = s_tuser;

  // Slot lanes; lanes beyond the stream fields see zero
  for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_lane
    if (i < SLOT_FIELDS) begin : g_in
      assign lane_slot[i] = s_tdata[SLOT_LSB + i*KEY_W +: KEY_W];
    end else begin : g_zero
      assign lane_slot[i] = '0;
    end
    khrf_lane u_lane (
      .slot  (lane_slot[i]),
      .keys  (keys),
      .match (match[i])
    );
  end

  // Extra lane for the zero that fills the last slot after the hotkey drop
  khrf_lane u_fill_lane (
    .slot  ('0),
    .keys  (keys),
    .match (fill_match)
  );

  khrf_merge #(.KEY_SLOTS(KEY_SLOTS)) u_merge (
    .slots      (lane_slot),
    .match      (match),
    .fill_match (fill_match),
    .slots_out  (merged),
    .sel        (sel)
  );

  // Output slot fields beyond KEY_SLOTS read zero
  for (genvar j = 0; j < SLOT_FIELDS; j++) begin : g_out
    if (j < KEY_SLOTS) begin : g_keep
      assign out_slot[j] = merged[j];
    end else begin : g_zero
      assign out_slot[j] = '0;
    end
  end

  assign target_next = sel.update ? sel.code : target_code;

  // Key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      keys.hot      <= RST_HOTKEY;
      keys.first_a  <= RST_FIRST_A;
      keys.first_b  <= RST_FIRST_B;
      keys.second_a <= RST_SECOND_A;
      keys.second_b <= RST_SECOND_B;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HOTKEY:   keys.hot      <= cfg_data;
        REG_FIRST_A:  keys.first_a  <= cfg_data;
        REG_FIRST_B:  keys.first_b  <= cfg_data;
        REG_SECOND_A: keys.second_a <= cfg_data;
        REG_SECOND_B: keys.second_b <= cfg_data;
        default: ;
      endcase
    end
  end

  // LED and target state
  always_ff @(posedge clk) begin
    if (rst) begin
      led_bits    <= '0;
      target_code <= TGT_FIRST;
    end else if (accept) begin
      if (is_report) begin
        target_code <= target_next;
      end else begin
        led_bits <= s_tdata[LED_W-1:0];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept && is_report) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_report) begin
      m_tdata[KEY_W-1:0]                     <= s_tdata[2*KEY_W-1:KEY_W];
      m_tdata[KEY_W +: STATUS_W]             <= {target_next, led_bits};
      m_tdata[OUT_SLOT_LSB +: SLOT_FIELDS*KEY_W] <= out_slot;
      m_tdata[LED_LSB +: LED_W]              <= led_bits;
      m_tdata[71:OUT_USED]                   <= '0;
    end
  end

endmodule

### tb/kvm_hotkey_report_filter_chk.sv
// Scoreboard for the hotkey report filter: watches the stream and config ports,
// predicts every filtered report and compares it with the output transfer.
// Depends on khrf_pkg for key widths, register indexes and target codes.
module kvm_hotkey_report_filter_chk #(
  parameter int   KEY_SLOTS   = 6,
  parameter logic REPORT_MODE = 1'b1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [63:0]                    s_tdata,
  input  logic                           s_tuser,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [71:0]                    m_tdata,
  input  logic                           cfg_we,
  input  logic [khrf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [khrf_pkg::KEY_W-1:0]     cfg_data,
  output int                             fail_count,
  output int                             open_reports
);
  timeunit 1ns;
  timeprecision 1ps;
  import khrf_pkg::*;

  typedef logic [SLOT_FIELDS-1:0][KEY_W-1:0] keys_t;

  typedef struct packed {
    logic  hit;
    keys_t keys;
  } strip_t;

  typedef struct {
    logic [KEY_W-1:0]    modifier;
    logic [STATUS_W-1:0] status;
    keys_t               keys;
    logic [LED_W-1:0]    led;
  } report_t;

  key_cfg_t         key_regs;
  logic [LED_W-1:0] led_state;
  logic [TGT_W-1:0] target_state;
  report_t          pending_reports[$];

  // Drop the first slot holding code; later slots move down, last slot clears
  function automatic strip_t strip_key(keys_t keys, logic [KEY_W-1:0] code);
    strip_t r;
    r.hit  = 1'b0;
    r.keys = keys;
    for (int p = 0; p < KEY_SLOTS; p++) begin
      if (!r.hit && keys[p] == code) r.hit = 1'b1;
      if (r.hit) begin
        if (p == KEY_SLOTS - 1) r.keys[p] = '0;
        else r.keys[p] = keys[p + 1];
      end
    end
    return r;
  endfunction

  // Filter one keyboard report; updates the target state
  function automatic report_t filter_report(logic [KEY_W-1:0] modifier, keys_t keys_in);
    report_t rep;
    strip_t  s;
    keys_t   keys;
    keys = '0;
    for (int i = 0; i < KEY_SLOTS && i < SLOT_FIELDS; i++) keys[i] = keys_in[i];
    s = strip_key(keys, key_regs.hot);
    if (s.hit) begin
      keys = s.keys;
      s = strip_key(keys, key_regs.first_a);
      if (!s.hit) s = strip_key(keys, key_regs.first_b);
      if (s.hit) begin
        keys         = s.keys;
        target_state = TGT_FIRST;
      end else begin
        s = strip_key(keys, key_regs.second_a);
        if (!s.hit) s = strip_key(keys, key_regs.second_b);
        if (s.hit) begin
          keys         = s.keys;
          target_state = TGT_SECOND;
        end
      end
    end
    rep.modifier = modifier;
    rep.status   = {target_state, led_state};
    rep.keys     = keys;
    rep.led      = led_state;
    return rep;
  endfunction

  task automatic check_report(report_t want, logic [71:0] got);
    keys_t got_keys;
    got_keys = got[62:15];
    if (got[7:0] !== want.modifier) begin
      $error("modifier_out: expected %0d, got %0d", want.modifier, got[7:0]);
      fail_count++;
    end
    if (got[14:8] !== want.status) begin
      $error("status_byte: expected %0d, got %0d", want.status, got[14:8]);
      fail_count++;
    end
    for (int i = 0; i < SLOT_FIELDS; i++) begin
      if (got_keys[i] !== want.keys[i]) begin
        $error("slot_out%0d: expected %0d, got %0d", i, want.keys[i], got_keys[i]);
        fail_count++;
      end
    end
    if (got[67:63] !== want.led) begin
      $error("led_report: expected %0d, got %0d", want.led, got[67:63]);
      fail_count++;
    end
    if (got[71:68] !== 4'd0) begin
      $error("pad: expected 0, got %0d", got[71:68]);
      fail_count++;
    end
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    if (rst) begin
      key_regs     <= '{hot: RST_HOTKEY, first_a: RST_FIRST_A, first_b: RST_FIRST_B,
                        second_a: RST_SECOND_A, second_b: RST_SECOND_B};
      led_state    <= '0;
      target_state <= TGT_FIRST;
      pending_reports.delete();
      open_reports <= 0;
    end else begin
      // Output side first: a result never stems from a same-cycle input
      if (m_tvalid && m_tready) begin
        if (pending_reports.size() == 0) begin
          $error("result transfer with no report outstanding: %h", m_tdata);
          fail_count++;
        end else begin
          check_report(pending_reports.pop_front(), m_tdata);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_HOTKEY:   key_regs.hot      = cfg_data;
          REG_FIRST_A:  key_regs.first_a  = cfg_data;
          REG_FIRST_B:  key_regs.first_b  = cfg_data;
          REG_SECOND_A: key_regs.second_a = cfg_data;
          REG_SECOND_B: key_regs.second_b = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == REPORT_MODE) begin
          pending_reports.push_back(filter_report(s_tdata[15:8], s_tdata[63:16]));
        end else begin
          led_state = s_tdata[LED_W-1:0];
        end
      end
      open_reports <= pending_reports.size();
    end
  end

endmodule

### tb/kvm_hotkey_report_filter_tb.sv
// Top of the hotkey report filter testbench: clock, reset, stimulus and verdict.
// Depends on khrf_pkg, kvm_hotkey_report_filter and kvm_hotkey_report_filter_chk.
module kvm_hotkey_report_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import khrf_pkg::*;

  localparam logic MODE_LED    = 1'b0;
  localparam logic MODE_REPORT = 1'b1;
  localparam int   QUIET_LIMIT = 2000;
  localparam int   HOLD_OFF    = 3;
  localparam int   SEG_ITEMS   = 270;

  typedef logic [SLOT_FIELDS-1:0][KEY_W-1:0] keys_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [63:0]          s_tdata = '0;
  logic                 s_tuser = MODE_LED;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [71:0]          m_tdata;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_HOTKEY;
  logic [KEY_W-1:0]     cfg_data = '0;

  int fail_count;
  int open_reports;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int quiet_cycles = 0;

  // Stimulus copy of the key registers, used to aim reports at them
  logic [KEY_W-1:0] key_vals [5];

  kvm_hotkey_report_filter DUT (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .cfg_we, .cfg_index, .cfg_data
  );

  kvm_hotkey_report_filter_chk #(.REPORT_MODE(MODE_REPORT)) u_chk (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .cfg_we, .cfg_index, .cfg_data,
    .fail_count, .open_reports
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // Watchdog on cycles with no transfer at all
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("kvm_hotkey_report_filter_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic keys_t keys6(logic [7:0] k0, k1, k2, k3, k4, k5);
    return {k5, k4, k3, k2, k1, k0};
  endfunction

  // Empty slots or configured codes half the time, so matches are frequent
  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(7))
      0:       return '0;
      1, 2, 3: return key_vals[$urandom_range(4)];
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_item(logic mode, logic [7:0] link, logic [7:0] modifier, keys_t keys);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {keys, modifier, link};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_report(logic [7:0] modifier, keys_t keys);
    send_item(MODE_REPORT, 8'($urandom_range(255)), modifier, keys);
  endtask

  task automatic send_led(logic [7:0] link);
    send_item(MODE_LED, link, 8'($urandom_range(255)), keys_t'({$urandom, $urandom}));
  endtask

  // Stop sending and let every outstanding report drain
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (open_reports != 0) @(posedge clk);
    repeat (HOLD_OFF) @(posedge clk);
  endtask

  task automatic write_keys(logic [7:0] hot, fa, fb, sa, sb);
    key_vals = '{hot, fa, fb, sa, sb};
    drain();
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_HOTKEY + CFG_IDX_W'(i);
      cfg_data  <= key_vals[i];
      @(posedge clk);
    end
    // Index past the last register must be ignored
    cfg_index <= REG_SECOND_B + CFG_IDX_W'($urandom_range(1, 3));
    cfg_data  <= 8'($urandom_range(255));
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random(int count);
    keys_t keys;
    int    r;
    int    pos;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 12) begin
        send_led(8'($urandom_range(255)));
      end else if (r < 82) begin
        // Hotkey present, often with a target key somewhere else
        for (int i = 0; i < SLOT_FIELDS; i++) keys[i] = pick_key();
        pos = $urandom_range(SLOT_FIELDS - 1);
        keys[pos] = key_vals[0];
        if ($urandom_range(99) < 60) keys[$urandom_range(SLOT_FIELDS - 1)] =
          key_vals[$urandom_range(1, 4)];
        send_report(8'($urandom_range(255)), keys);
      end else begin
        send_report(8'($urandom_range(255)), keys_t'({$urandom, $urandom}));
      end
    end
  endtask

  initial begin
    logic [7:0] h, fa, fb, sa, sb;
    int seg;
    key_vals = '{RST_HOTKEY, RST_FIRST_A, RST_FIRST_B, RST_SECOND_A, RST_SECOND_B};
    tx_idle_pct  = 37;
    rx_stall_pct = 65;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed reports under the reset key codes
    h  = RST_HOTKEY;
    fa = RST_FIRST_A;
    fb = RST_FIRST_B;
    sa = RST_SECOND_A;
    sb = RST_SECOND_B;
    send_led(8'hFF);
    send_report(8'hFF, keys6(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_report(8'h00, keys6(0, 0, 0, 0, 0, 0));
    send_report(8'h01, keys6(h, fa, 0, 0, 0, 0));
    send_led(8'hE0);                                       // upper bits dropped
    send_report(8'h02, keys6(fb, h, 4, 5, 6, 7));          // alternate first key
    send_report(8'h04, keys6(h, sa, 0, 0, 0, 0));
    send_report(8'h08, keys6(4, sb, h, 0, 0, 0));          // alternate second key
    send_report(8'h10, keys6(fa, fb, h, 0, 0, 0));         // only key_a removed
    send_report(8'h20, keys6(sa, fa, h, 9, 0, 0));         // first target wins
    send_report(8'h40, keys6(h, h, fa, fa, 0, 0));         // first occurrences only
    send_report(8'h80, keys6(4, 5, 6, 7, 8, h));           // hotkey in last slot
    send_report(8'h55, keys6(h, 4, 5, 6, 7, fa));
    send_report(8'hAA, keys6(fa, sa, sb, fb, 0, 0));       // no hotkey: untouched
    send_report(8'h00, keys6(h, 4, 5, 6, 7, 8));           // hotkey, no target key
    send_led(8'h15);
    send_report(8'h3C, keys6(sb, sa, h, 0, 0, 0));
    send_report(8'hAA, keys6(h, sb, sb, 0, 0, 0));
    send_led(8'h1F);
    send_report(8'hC3, keys6(8'hFF, 0, 8'hFF, h, fa, 8'h80));
    send_report(8'h00, keys6(h, fb, fb, sa, 0, 0));

    // Random traffic: three idling profiles, two key settings each
    for (int p = 0; p < 3; p++) begin
      tx_idle_pct  = (p == 0) ? 37 : (p == 1) ? 65 : 0;
      rx_stall_pct = (p == 0) ? 65 : (p == 1) ? 37 : 0;
      for (int k = 0; k < 2; k++) begin
        seg = p * 2 + k;
        h  = 8'($urandom_range(255));
        fa = 8'($urandom_range(255));
        fb = 8'($urandom_range(255));
        sa = 8'($urandom_range(255));
        sb = 8'($urandom_range(255));
        case (seg)
          0: write_keys(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
          1: write_keys(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
          3: write_keys(h, h, fb, fb, sb);                 // overlapping codes
          5: write_keys(RST_HOTKEY, RST_FIRST_A, RST_FIRST_B, RST_SECOND_A,
                        RST_SECOND_B);
          default: write_keys(h, fa, fb, sa, sb);
        endcase
        run_random(SEG_ITEMS);
      end
    end

    drain();
    if (fail_count == 0 && open_reports == 0) begin
      $display("kvm_hotkey_report_filter_tb: clean");
    end else begin
      $display("kvm_hotkey_report_filter_tb: errors");
    end
    $finish;
  end

endmodule
